// ===== sv/iaqs_pkg.sv =====
package iaqs_pkg;

    typedef enum logic [2:0] {
        LK_TEMP,
        LK_RH,
        LK_CO2,
        LK_PM,
        LK_NOX,
        LK_VOC
    } t_lane_kind;

    typedef enum logic [1:0] {
        CFG_BAD_THRESHOLD = 2'd0,
        CFG_PENALTY_STEP  = 2'd1,
        CFG_COMFORT_GAIN  = 2'd2
    } t_cfg_idx;

    localparam int VALUE_W   = 18;
    localparam int OFF_W     = 14;
    localparam int RCP_SHIFT = 14;
    localparam int SPAN2_W   = 15;
    localparam int MAG_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 10;
    localparam int THR_W     = 9;
    localparam int PEN_W     = 9;
    localparam int GAIN_W    = 10;
    localparam int SCORE_W   = 9;
    localparam int GOOD_W    = 14;
    localparam int BAD_W     = 3;
    localparam int NUM_POL   = 4;
    localparam int LATENCY   = 11;

    localparam logic [THR_W-1:0]  THR_RESET  = 9'd300;
    localparam logic [PEN_W-1:0]  PEN_RESET  = 9'd50;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd100;

    // Breakpoints in input units, scores in half points.
    localparam int TEMP_BP [10] = '{0, 8000, 16000, 18000, 20000, 25000, 27000, 29000,
                                    34000, 35000};
    localparam int TEMP_SC [10] = '{10, 10, 8, 6, 2, 0, 2, 6, 8, 10};
    localparam int RH_BP   [10] = '{0, 1400, 2300, 3000, 4000, 5000, 6000, 6500, 8000, 8500};
    localparam int RH_SC   [10] = '{10, 10, 8, 6, 2, 0, 2, 6, 8, 10};
    localparam int CO2_BP  [6]  = '{0, 420, 800, 1000, 1400, 4500};
    localparam int CO2_SC  [6]  = '{0, 0, 2, 4, 6, 10};
    localparam int PM_BP   [6]  = '{0, 500, 1200, 3500, 5500, 15000};
    localparam int PM_SC   [6]  = '{0, 2, 4, 6, 8, 10};
    localparam int NOX_BP  [6]  = '{0, 1, 90, 150, 300, 310};
    localparam int NOX_SC  [6]  = '{0, 1, 4, 6, 8, 10};
    localparam int VOC_BP  [6]  = '{0, 100, 150, 250, 400, 410};
    localparam int VOC_SC  [6]  = '{0, 1, 4, 6, 8, 10};

    function automatic int npts_of(t_lane_kind k);
        case (k)
            LK_TEMP: return 10;
            LK_RH:   return 10;
            default: return 6;
        endcase
    endfunction

    function automatic int bp_of(t_lane_kind k, int i);
        case (k)
            LK_TEMP: return TEMP_BP[i];
            LK_RH:   return RH_BP[i];
            LK_CO2:  return CO2_BP[i];
            LK_PM:   return PM_BP[i];
            LK_NOX:  return NOX_BP[i];
            LK_VOC:  return VOC_BP[i];
            default: return 0;
        endcase
    endfunction

    function automatic int sc_of(t_lane_kind k, int i);
        case (k)
            LK_TEMP: return TEMP_SC[i];
            LK_RH:   return RH_SC[i];
            LK_CO2:  return CO2_SC[i];
            LK_PM:   return PM_SC[i];
            LK_NOX:  return NOX_SC[i];
            LK_VOC:  return VOC_SC[i];
            default: return 0;
        endcase
    endfunction

endpackage

// ===== sv/iaqs_lane.sv =====
module iaqs_lane import iaqs_pkg::*; #(
    parameter t_lane_kind KIND = LK_CO2,
    parameter int FB = 16
) (
    input  logic                      i_clk,
    input  logic [3:0]                i_en,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic [FB+2:0]             o_sub
);

    localparam int NP   = npts_of(KIND);
    localparam int NSEG = NP - 1;
    localparam int SGW  = $clog2(NSEG);
    localparam int KW   = FB + RCP_SHIFT;
    localparam int EW   = FB + 2;
    localparam int NW   = FB + 18;
    localparam int SUBW = FB + 3;
    localparam int PW   = OFF_W + KW;

    logic signed [VALUE_W-1:0] w_bp  [NP];
    logic [KW-1:0]             w_k   [NSEG];
    logic [SPAN2_W-1:0]        w_d   [NSEG];
    logic [MAG_W-1:0]          w_mag [NSEG];
    logic [SUBW-1:0]           w_low [NSEG];
    logic                      w_dec [NSEG];

    for (genvar g = 0; g < NP; g++) begin : g_bp
        localparam int BPV = bp_of(KIND, g);
        assign w_bp[g] = VALUE_W'(BPV);
    end

    // The reciprocal of twice the span, scaled by the segment slope.
    for (genvar g = 0; g < NSEG; g++) begin : g_seg
        localparam int SPAN = bp_of(KIND, g + 1) - bp_of(KIND, g);
        localparam int SC_A = sc_of(KIND, g);
        localparam int SC_B = sc_of(KIND, g + 1);
        localparam int MAG  = (SC_B > SC_A) ? (SC_B - SC_A) : (SC_A - SC_B);
        localparam logic [63:0] KV   = (64'(MAG) << (FB + RCP_SHIFT)) / 64'(2 * SPAN);
        localparam logic [63:0] LOWV = 64'(SC_A) << (FB - 1);
        assign w_k[g]   = KV[KW-1:0];
        assign w_d[g]   = SPAN2_W'(2 * SPAN);
        assign w_mag[g] = MAG_W'(MAG);
        assign w_low[g] = LOWV[SUBW-1:0];
        assign w_dec[g] = (SC_B < SC_A);
    end

    logic [SGW-1:0]   r_seg1, n_seg1, r_seg2, r_seg3;
    logic [OFF_W-1:0] r_off1, n_off1;
    logic [PW-1:0]    w_prod;
    logic [EW-1:0]    r_est2, n_est2, r_est3, w_step;
    logic [NW-1:0]    r_num2, n_num2, r_num3;
    logic [NW-1:0]    r_rhs3, n_rhs3;
    logic [SUBW-1:0]  r_sub4, n_sub4;

    // Readings outside the table map to the start of the first segment or the end of the last segment.
    always_comb begin
        n_seg1 = SGW'(NSEG - 1);
        n_off1 = OFF_W'(w_bp[NP-1] - w_bp[NP-2]);
        for (int i = NSEG - 1; i >= 0; i--) begin
            if (i_value <= w_bp[i+1]) begin
                n_seg1 = SGW'(i);
                n_off1 = OFF_W'(i_value - w_bp[i]);
            end
        end
        if (i_value <= w_bp[0]) begin
            n_seg1 = '0;
            n_off1 = '0;
        end
    end

    always_comb begin
        w_prod = PW'(r_off1) * PW'(w_k[r_seg1]);
        n_est2 = w_prod[RCP_SHIFT +: EW];
        n_num2 = (NW'(r_off1) * NW'(w_mag[r_seg1])) << FB;
    end

    assign n_rhs3 = (NW'(r_est2) + NW'(1)) * NW'(w_d[r_seg2]);

    // The reciprocal estimate is at most one below the true quotient.
    always_comb begin
        w_step = (r_num3 >= r_rhs3) ? (r_est3 + EW'(1)) : r_est3;
        if (w_dec[r_seg3]) begin
            n_sub4 = w_low[r_seg3] - SUBW'(w_step);
        end else begin
            n_sub4 = w_low[r_seg3] + SUBW'(w_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_seg1 <= n_seg1;
            r_off1 <= n_off1;
        end
        if (i_en[1]) begin
            r_seg2 <= r_seg1;
            r_est2 <= n_est2;
            r_num2 <= n_num2;
        end
        if (i_en[2]) begin
            r_seg3 <= r_seg2;
            r_est3 <= r_est2;
            r_num3 <= r_num2;
            r_rhs3 <= n_rhs3;
        end
        if (i_en[3]) begin
            r_sub4 <= n_sub4;
        end
    end

    assign o_sub = r_sub4;

endmodule

// ===== sv/iaqs_comfort.sv =====
module iaqs_comfort import iaqs_pkg::*; #(
    parameter int FB = 16
) (
    input  logic              i_clk,
    input  logic [3:0]        i_en,
    input  logic [FB+2:0]     i_sub,
    input  logic [GAIN_W-1:0] i_gain,
    output logic [FB+2:0]     o_mult
);

    localparam int SUBW = FB + 3;
    localparam int DPW  = SUBW + GAIN_W;
    localparam int YW   = FB + 12;
    localparam int RW   = FB + 3;
    localparam int EW   = FB + 3;
    localparam int QW   = FB + 14;
    localparam int MW   = FB + 3;
    localparam int MW1  = MW + 1;
    localparam int PW   = YW + RW;

    localparam logic [SUBW-1:0] ONE   = SUBW'(1) << FB;
    localparam logic [MW1-1:0]  ONE_M = MW1'(1) << FB;
    localparam logic [63:0]     RCP   = (64'd1 << YW) / 64'd1000;

    logic [SUBW-1:0] w_diff;
    logic [YW-1:0]   r_ya, n_ya, r_yb, r_yc;
    logic [PW-1:0]   w_prod;
    logic [EW-1:0]   r_eb, n_eb, r_ec;
    logic [QW-1:0]   r_qc, n_qc;
    logic [MW1-1:0]  w_quot;
    logic [MW-1:0]   r_m, n_m;

    always_comb begin
        w_diff = i_sub - ONE;
        n_ya   = (i_sub > ONE) ? YW'(DPW'(w_diff) * DPW'(i_gain)) : '0;
    end

    // Division by one thousand: reciprocal estimate, then a single correction.
    always_comb begin
        w_prod = PW'(r_ya) * PW'(RCP[RW-1:0]);
        n_eb   = w_prod[YW +: EW];
    end

    assign n_qc = (QW'(r_eb) + QW'(1)) * QW'(1000);

    always_comb begin
        w_quot = (QW'(r_yc) >= r_qc) ? (MW1'(r_ec) + MW1'(1)) : MW1'(r_ec);
        n_m    = MW'(ONE_M + w_quot);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ya <= n_ya;
        end
        if (i_en[1]) begin
            r_yb <= r_ya;
            r_eb <= n_eb;
        end
        if (i_en[2]) begin
            r_yc <= r_yb;
            r_ec <= r_eb;
            r_qc <= n_qc;
        end
        if (i_en[3]) begin
            r_m <= n_m;
        end
    end

    assign o_mult = r_m;

endmodule

// ===== sv/indoor_air_quality_score.sv =====
// Channel   Handshake            Payload
// input     i_valid / o_stall    i_temp_milli_c, i_rh_centi_pct, i_co2_ppm,
//                                i_pm25_centi_ug, i_nox_index, i_voc_index
// output    o_valid / i_stall    o_score_centi, o_goodness_centi_pct, o_base_centi,
//                                o_bad_count
// config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// One input transfer can be taken every cycle while o_stall is low. A result passes through
// the six interpolation lanes, the comfort multiplier units and the two scaling
// multiplies, each multiply with its own register, then the final rounding register.
// Each stage loads when it is empty or when the stage after it moves, so bubbles are
// squeezed out while the output is stalled. Reset clears all stage valid bits and
// loads the registers with 300, 50 and 100.
module indoor_air_quality_score import iaqs_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [VALUE_W-1:0] i_temp_milli_c,
    input  logic [13:0]               i_rh_centi_pct,
    input  logic [15:0]               i_co2_ppm,
    input  logic [16:0]               i_pm25_centi_ug,
    input  logic [8:0]                i_nox_index,
    input  logic [8:0]                i_voc_index,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [SCORE_W-1:0]        o_score_centi,
    output logic [GOOD_W-1:0]         o_goodness_centi_pct,
    output logic [SCORE_W-1:0]        o_base_centi,
    output logic [BAD_W-1:0]          o_bad_count,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    localparam int FB   = FRACTION_BITS;
    localparam int SUBW = FB + 3;
    localparam int MW   = FB + 3;
    localparam int PCW  = FB + 10;
    localparam int BW   = FB + 9;
    localparam int BW1  = BW + 1;
    localparam int BFW  = FB + 12;
    localparam int MPW  = BW + MW;

    localparam logic [BW-1:0]  LIMIT = BW'(500) << FB;
    localparam logic [BW1-1:0] HALF  = BW1'(1) << (FB - 1);

    logic [THR_W-1:0]  r_thr;
    logic [PEN_W-1:0]  r_pen;
    logic [GAIN_W-1:0] r_gain;

    logic [LATENCY:1]   r_vld, n_vld;
    logic [LATENCY+1:1] w_en;

    logic signed [VALUE_W-1:0] w_val_rh, w_val_co2, w_val_pm, w_val_nox, w_val_voc;
    logic [SUBW-1:0] w_ts, w_hs;
    logic [SUBW-1:0] w_pol [NUM_POL];
    logic [MW-1:0]   w_mt, w_mh;

    logic [SUBW-1:0]    r_max5, n_max5;
    logic [BAD_W-1:0]   r_bad5, n_bad5, r_bad6, r_bad7, r_bad8, r_bad9, r_bad10, r_bad11;
    logic [BFW-1:0]     w_base6;
    logic [BW-1:0]      r_base6, n_base6, r_base7, r_base8;
    logic [SCORE_W-1:0] r_bc7, n_bc7, r_bc8, r_bc9, r_bc10, r_bc11;
    logic [MPW-1:0]     w_p9, w_p10;
    logic [BW-1:0]      r_p9, n_p9, r_p10, n_p10;
    logic [MW-1:0]      r_mh9;
    logic [SCORE_W-1:0] r_score11, n_score11;
    logic [GOOD_W-1:0]  r_good11, n_good11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RESET;
            r_pen  <= PEN_RESET;
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BAD_THRESHOLD: r_thr  <= i_cfg_data[THR_W-1:0];
                CFG_PENALTY_STEP:  r_pen  <= i_cfg_data[PEN_W-1:0];
                CFG_COMFORT_GAIN:  r_gain <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_en[LATENCY+1] = !i_stall;
        for (int k = LATENCY; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign n_vld   = {r_vld[LATENCY-1:1], i_valid};
    assign o_stall = !w_en[1];
    assign o_valid = r_vld[LATENCY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= LATENCY; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign w_val_rh  = VALUE_W'(i_rh_centi_pct);
    assign w_val_co2 = VALUE_W'(i_co2_ppm);
    assign w_val_pm  = VALUE_W'(i_pm25_centi_ug);
    assign w_val_nox = VALUE_W'(i_nox_index);
    assign w_val_voc = VALUE_W'(i_voc_index);

    iaqs_lane #(.KIND(LK_TEMP), .FB(FB)) u_lane_temp (
        .i_clk(i_clk), .i_en(w_en[4:1]), .i_value(i_temp_milli_c), .o_sub(w_ts)
    );
    iaqs_lane #(.KIND(LK_RH), .FB(FB)) u_lane_rh (
        .i_clk(i_clk), .i_en(w_en[4:1]), .i_value(w_val_rh), .o_sub(w_hs)
    );
    iaqs_lane #(.KIND(LK_CO2), .FB(FB)) u_lane_co2 (
        .i_clk(i_clk), .i_en(w_en[4:1]), .i_value(w_val_co2), .o_sub(w_pol[0])
    );
    iaqs_lane #(.KIND(LK_PM), .FB(FB)) u_lane_pm (
        .i_clk(i_clk), .i_en(w_en[4:1]), .i_value(w_val_pm), .o_sub(w_pol[1])
    );
    iaqs_lane #(.KIND(LK_NOX), .FB(FB)) u_lane_nox (
        .i_clk(i_clk), .i_en(w_en[4:1]), .i_value(w_val_nox), .o_sub(w_pol[2])
    );
    iaqs_lane #(.KIND(LK_VOC), .FB(FB)) u_lane_voc (
        .i_clk(i_clk), .i_en(w_en[4:1]), .i_value(w_val_voc), .o_sub(w_pol[3])
    );

    iaqs_comfort #(.FB(FB)) u_comfort_temp (
        .i_clk(i_clk), .i_en(w_en[8:5]), .i_sub(w_ts), .i_gain(r_gain), .o_mult(w_mt)
    );
    iaqs_comfort #(.FB(FB)) u_comfort_rh (
        .i_clk(i_clk), .i_en(w_en[8:5]), .i_sub(w_hs), .i_gain(r_gain), .o_mult(w_mh)
    );

    always_comb begin
        n_max5 = w_pol[0];
        n_bad5 = '0;
        for (int i = 0; i < NUM_POL; i++) begin
            if (w_pol[i] > n_max5) begin
                n_max5 = w_pol[i];
            end
            if ((PCW'(w_pol[i]) * PCW'(100)) > (PCW'(r_thr) << FB)) begin
                n_bad5 = n_bad5 + BAD_W'(1);
            end
        end
    end

    // Each bad pollutant after the first adds one penalty step.
    always_comb begin
        w_base6 = BFW'(r_max5) * BFW'(100);
        if (r_bad5 > BAD_W'(1)) begin
            w_base6 = w_base6 + ((BFW'(r_bad5 - BAD_W'(1)) * BFW'(r_pen)) << FB);
        end
        n_base6 = (w_base6 > BFW'(LIMIT)) ? LIMIT : w_base6[BW-1:0];
    end

    assign n_bc7 = SCORE_W'((BW1'(r_base6) + HALF) >> FB);

    always_comb begin
        w_p9  = (MPW'(r_base8) * MPW'(w_mt)) >> FB;
        n_p9  = (w_p9 > MPW'(LIMIT)) ? LIMIT : w_p9[BW-1:0];
        w_p10 = (MPW'(r_p9) * MPW'(r_mh9)) >> FB;
        n_p10 = (w_p10 > MPW'(LIMIT)) ? LIMIT : w_p10[BW-1:0];
    end

    always_comb begin
        n_score11 = SCORE_W'((BW1'(r_p10) + HALF) >> FB);
        n_good11  = GOOD_W'(10000) - GOOD_W'(20) * GOOD_W'(n_score11);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_max5 <= n_max5;
            r_bad5 <= n_bad5;
        end
        if (w_en[6]) begin
            r_base6 <= n_base6;
            r_bad6  <= r_bad5;
        end
        if (w_en[7]) begin
            r_base7 <= r_base6;
            r_bc7   <= n_bc7;
            r_bad7  <= r_bad6;
        end
        if (w_en[8]) begin
            r_base8 <= r_base7;
            r_bc8   <= r_bc7;
            r_bad8  <= r_bad7;
        end
        if (w_en[9]) begin
            r_p9   <= n_p9;
            r_mh9  <= w_mh;
            r_bc9  <= r_bc8;
            r_bad9 <= r_bad8;
        end
        if (w_en[10]) begin
            r_p10   <= n_p10;
            r_bc10  <= r_bc9;
            r_bad10 <= r_bad9;
        end
        if (w_en[11]) begin
            r_score11 <= n_score11;
            r_good11  <= n_good11;
            r_bc11    <= r_bc10;
            r_bad11   <= r_bad10;
        end
    end

    assign o_score_centi        = r_score11;
    assign o_goodness_centi_pct = r_good11;
    assign o_base_centi         = r_bc11;
    assign o_bad_count          = r_bad11;

endmodule
